@@ hdl/ddo_pkg.sv @@
// Shared constants and functions of the differential-drive odometry block.
package ddo_pkg;

  localparam int CORDIC_STEPS_DEF = 24;

  localparam int unsigned RADIUS_RESET = 2163;
  localparam int unsigned SEP_RESET    = 409600;
  localparam logic signed [31:0] X_RESET = -32'sd32768;

  localparam int unsigned DT_FALLBACK_US = 10000;
  localparam int unsigned DT_LIMIT_US    = 10000000;
  localparam int unsigned US_PER_S       = 1000000;
  localparam int unsigned BAM_PER_RAD_US = 44798134;
  localparam logic [31:0] CORDIC_GAIN    = 32'h26DD3B6A;

  // Datapath widths
  localparam int DT_W    = 24;
  localparam int TRIG_W  = 34;
  localparam int MUL_AW  = 60;
  localparam int MUL_BW  = 34;
  localparam int DIV_W   = 60;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_RADIUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_SEP      = 2'd1;

  function automatic logic [31:0] atan_bam(input logic [4:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0:  r = 32'h20000000;  5'd1:  r = 32'h12E4051D;
      5'd2:  r = 32'h09FB385B;  5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;  5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;  5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;  5'd9:  r = 32'h00145F2E;
      5'd10: r = 32'h000A2F98;  5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;  5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2F9;  5'd15: r = 32'h0000517C;
      5'd16: r = 32'h000028BE;  5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A2F;  5'd19: r = 32'h00000517;
      5'd20: r = 32'h0000028B;  5'd21: r = 32'h00000145;
      5'd22: r = 32'h000000A2;  5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000028;  5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;  5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000002;  5'd29: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

@@ hdl/ddo_if.sv @@
// Valid/ready channel interfaces for wheel samples and pose results.
interface ddo_in_if;
  logic               valid;
  logic               ready;
  logic               speeds_present;
  logic signed [31:0] left_speed;
  logic signed [31:0] right_speed;
  logic [47:0]        stamp_us;
  modport source (output valid, speeds_present, left_speed, right_speed, stamp_us,
                  input ready);
  modport sink (input valid, speeds_present, left_speed, right_speed, stamp_us,
                output ready);
endinterface

interface ddo_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] heading;
  logic signed [31:0] linear_speed;
  logic signed [31:0] turn_rate;
  logic [47:0]        out_stamp_us;
  modport source (output valid, pos_x, pos_y, heading, linear_speed, turn_rate,
                  out_stamp_us, input ready);
  modport sink (input valid, pos_x, pos_y, heading, linear_speed, turn_rate,
                out_stamp_us, output ready);
endinterface

@@ hdl/ddo_sermul.sv @@
// Bit-serial signed multiplier, one multiplier bit per cycle.
module ddo_sermul #(
  parameter int WA = 60,
  parameter int WB = 34
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [WA-1:0]    a,
  input  logic signed [WB-1:0]    b,
  output logic                    busy,
  output logic                    done,
  output logic signed [WA+WB-1:0] p
);
  localparam int CW = $clog2(WB + 1);

  logic signed [WA:0]   hi_r;
  logic [WB-1:0]        lo_r;
  logic signed [WA-1:0] a_r;
  logic [CW-1:0]        cnt_r;
  logic                 busy_r;
  logic                 done_r;

  logic signed [WA:0] a_ext;
  logic signed [WA:0] addend;
  logic signed [WA:0] sum;
  logic               last;

  always_comb begin
    a_ext = {a_r[WA-1], a_r};
    last  = (cnt_r == CW'(WB - 1));
    if (lo_r[0]) begin
      // top bit of a signed multiplier has negative weight
      addend = last ? -a_ext : a_ext;
    end else begin
      addend = '0;
    end
    sum = hi_r + addend;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        hi_r   <= '0;
        lo_r   <= b;
        a_r    <= a;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        hi_r  <= sum >>> 1;
        lo_r  <= {sum[0], lo_r[WB-1:1]};
        cnt_r <= cnt_r + 1'b1;
        if (last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign p    = {hi_r[WA-1:0], lo_r};
endmodule

@@ hdl/ddo_cdiv.sv @@
// Bit-serial restoring division of an unsigned value by one microsecond scale.
module ddo_cdiv #(
  parameter int W = 60
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] num,
  output logic         done,
  output logic [W-1:0] quo
);
  localparam int RW = $clog2(ddo_pkg::US_PER_S) + 1;
  localparam logic [RW-1:0] DIVISOR = RW'(ddo_pkg::US_PER_S);
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  num_r;
  logic [RW-1:0] rem_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;

  logic [RW-1:0] trial;
  logic          fits;

  always_comb begin
    trial = {rem_r[RW-2:0], num_r[W-1]};
    fits  = (trial >= DIVISOR);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        num_r  <= num;
        rem_r  <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= fits ? trial - DIVISOR : trial;
        num_r <= {num_r[W-2:0], fits};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = num_r;
endmodule

@@ hdl/ddo_cordic.sv @@
// Iterative rotation-mode CORDIC giving cos and sin of a binary angle.
module ddo_cordic #(
  parameter int STEPS = 24
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  input  logic [31:0]                            ang,
  output logic                                   busy,
  output logic signed [ddo_pkg::TRIG_W-1:0]      cos_o,
  output logic signed [ddo_pkg::TRIG_W-1:0]      sin_o
);
  localparam int TW = ddo_pkg::TRIG_W;
  localparam int CW = $clog2(STEPS + 1);

  logic signed [TW-1:0] x_r, y_r;
  logic [31:0]          z_r;
  logic [CW-1:0]        i_r;
  logic                 busy_r;

  logic signed [TW-1:0] dx, dy, gain;
  logic [31:0]          at;
  logic [4:0]           idx;
  logic                 flip;

  always_comb begin
    idx  = 5'(i_r);
    dx   = y_r >>> idx;
    dy   = x_r >>> idx;
    at   = ddo_pkg::atan_bam(idx);
    gain = TW'(ddo_pkg::CORDIC_GAIN);
    // left half-plane: turn by half a turn and start from the negated vector
    flip = (ang[31:30] == 2'b01) || (ang[31:30] == 2'b10);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      i_r    <= '0;
    end else begin
      if (start) begin
        x_r    <= flip ? -gain : gain;
        y_r    <= '0;
        z_r    <= flip ? ang + 32'h80000000 : ang;
        i_r    <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (!z_r[31]) begin
          x_r <= x_r - dx;
          y_r <= y_r + dy;
          z_r <= z_r - at;
        end else begin
          x_r <= x_r + dx;
          y_r <= y_r - dy;
          z_r <= z_r + at;
        end
        i_r <= i_r + 1'b1;
        if (i_r == CW'(STEPS - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign busy  = busy_r;
  assign cos_o = x_r;
  assign sin_o = y_r;
endmodule

@@ hdl/diff_drive_odometry.sv @@
// Top level of the differential-drive odometry block.
//
// Usage: wheel-speed requests enter on in_chan (valid/ready). A request with
// speeds_present low is taken and dropped: no pose comes out and no state
// changes. Every other request moves the pose by one Euler step and yields
// one pose request on out_chan carrying position, heading, both speeds and
// the request's timestamp.
// Each request takes nine products on the bit-serial multiplier, two
// divisions by 10^6 on the bit-serial divider and a load of the output
// register. The block works on one request at a time and takes the next
// one in the cycle after the pose is loaded; most of the time goes to the
// shared one-bit-per-cycle multiplier. The CORDIC runs alongside the first
// multiplies.
// in_chan.ready is high only while no request is in work.
// A finished pose waits in the output register while the next request is
// taken; if the receiver still stalls when that one finishes, hold it there.
// Reset: pose x = -0.5 m, y = 0, heading 0, last timestamp 0, registers to
// their defaults. Configuration is written through cfg_we/cfg_index/cfg_wdata
// by the user while the block is idle, unchecked; unknown indexes are ignored.
module diff_drive_odometry #(
  parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [ddo_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [23:0]                   cfg_wdata,
  ddo_in_if.sink                        in_chan,
  ddo_out_if.source                     out_chan
);
  localparam int AW = ddo_pkg::MUL_AW;
  localparam int BW = ddo_pkg::MUL_BW;
  localparam int TW = ddo_pkg::TRIG_W;
  localparam int DW = ddo_pkg::DIV_W;
  localparam int DTW = ddo_pkg::DT_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SUM, ST_DIF, ST_ANG, ST_CX, ST_CY, ST_PX, ST_DX,
    ST_PY, ST_DY, ST_H1, ST_H2, ST_FIN
  } state_t;

  state_t state_r;

  // configuration
  logic [15:0] radius_r;
  logic [23:0] sep_r;

  // pose state
  logic signed [31:0] x_r, y_r;
  logic [31:0]        yaw_r;
  logic [47:0]        prev_r;

  // request in work
  logic signed [31:0] left_r, right_r;
  logic [47:0]        stamp_r;
  logic [DTW-1:0]     dt_r;
  logic signed [31:0] lin_r, ang_r;
  logic signed [32:0] d16_r;
  logic signed [35:0] px_r, py_r;
  logic [DW-1:0]      mag_r;
  logic               neg_r;
  logic signed [AW-1:0] hd_r;

  // output register
  logic               out_valid_r;
  logic signed [31:0] o_x_r, o_y_r, o_yaw_r, o_lin_r, o_ang_r;
  logic [47:0]        o_stamp_r;

  logic mul_start_r, div_start_r, cor_start;

  logic                   accept;
  logic signed [48:0]     diff;
  logic                   dt_bad;
  logic [DTW-1:0]         dt_new;
  logic signed [AW-1:0]   mul_a;
  logic signed [BW-1:0]   mul_b;
  logic                   mul_busy, mul_done;
  logic signed [AW+BW-1:0] mul_p;
  logic                   div_done;
  logic [DW-1:0]          div_q;
  logic                   cor_busy;
  logic signed [TW-1:0]   cos_v, sin_v;
  logic signed [DW:0]     step;
  logic signed [63:0]     pos_sum_x, pos_sum_y;
  logic signed [63:0]     ang_ext;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign accept = in_chan.valid && in_chan.ready;
  assign cor_start = accept && in_chan.speeds_present;

  // time step; fall back to 10 ms when not positive or beyond 10 s
  always_comb begin
    diff   = $signed({1'b0, in_chan.stamp_us}) - $signed({1'b0, prev_r});
    dt_bad = diff[48] || (diff == '0) || (diff > 49'(ddo_pkg::DT_LIMIT_US));
    dt_new = dt_bad ? DTW'(ddo_pkg::DT_FALLBACK_US) : diff[DTW-1:0];
  end

  // operand selection for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_SUM: begin
        mul_a = AW'($signed({left_r[31], left_r}) + $signed({right_r[31], right_r}));
        mul_b = $signed({{(BW-16){1'b0}}, radius_r});
      end
      ST_DIF: begin
        mul_a = AW'($signed({left_r[31], left_r}) - $signed({right_r[31], right_r}));
        mul_b = $signed({{(BW-16){1'b0}}, radius_r});
      end
      ST_ANG: begin
        mul_a = AW'(d16_r);
        mul_b = $signed({{(BW-24){1'b0}}, sep_r});
      end
      ST_CX: begin
        mul_a = AW'(lin_r);
        mul_b = cos_v;
      end
      ST_CY: begin
        mul_a = AW'(lin_r);
        mul_b = sin_v;
      end
      ST_PX: begin
        mul_a = AW'(px_r);
        mul_b = $signed({{(BW-DTW){1'b0}}, dt_r});
      end
      ST_PY: begin
        mul_a = AW'(py_r);
        mul_b = $signed({{(BW-DTW){1'b0}}, dt_r});
      end
      ST_H1: begin
        mul_a = AW'(ang_r);
        mul_b = $signed({{(BW-DTW){1'b0}}, dt_r});
      end
      ST_H2: begin
        mul_a = hd_r;
        mul_b = BW'(ddo_pkg::BAM_PER_RAD_US);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    step      = neg_r ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
    pos_sum_x = 64'(x_r) + 64'(step);
    pos_sum_y = 64'(y_r) + 64'(step);
    ang_ext   = {{22{mul_p[57]}}, mul_p[57:16]};
  end

  ddo_sermul #(.WA(AW), .WB(BW)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start_r), .a(mul_a), .b(mul_b),
    .busy(mul_busy), .done(mul_done), .p(mul_p)
  );

  ddo_cdiv #(.W(DW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start_r), .num(mag_r),
    .done(div_done), .quo(div_q)
  );

  ddo_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst_n(rst_n), .start(cor_start), .ang(yaw_r),
    .busy(cor_busy), .cos_o(cos_v), .sin_o(sin_v)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      radius_r    <= 16'(ddo_pkg::RADIUS_RESET);
      sep_r       <= 24'(ddo_pkg::SEP_RESET);
      x_r         <= ddo_pkg::X_RESET;
      y_r         <= '0;
      yaw_r       <= '0;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
      mul_start_r <= 1'b0;
      div_start_r <= 1'b0;
    end else begin
      mul_start_r <= 1'b0;
      div_start_r <= 1'b0;

      if (cfg_we) begin
        if (cfg_index == ddo_pkg::CFG_WHEEL_RADIUS) begin
          radius_r <= cfg_wdata[15:0];
        end else if (cfg_index == ddo_pkg::CFG_INV_SEP) begin
          sep_r <= cfg_wdata;
        end
      end

      // drop the taken pose; the final state reloads the register itself
      if (out_valid_r && out_chan.ready && (state_r != ST_FIN)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          // drop requests without speeds, state untouched
          if (accept && in_chan.speeds_present) begin
            left_r      <= in_chan.left_speed;
            right_r     <= in_chan.right_speed;
            stamp_r     <= in_chan.stamp_us;
            prev_r      <= in_chan.stamp_us;
            dt_r        <= dt_new;
            state_r     <= ST_SUM;
            mul_start_r <= 1'b1;
          end
        end
        ST_SUM: begin
          if (mul_done) begin
            lin_r       <= ddo_pkg::sat32({{31{mul_p[49]}}, mul_p[49:17]});
            state_r     <= ST_DIF;
            mul_start_r <= 1'b1;
          end
        end
        ST_DIF: begin
          if (mul_done) begin
            d16_r       <= mul_p[48:16];
            state_r     <= ST_ANG;
            mul_start_r <= 1'b1;
          end
        end
        ST_ANG: begin
          if (mul_done) begin
            ang_r       <= ddo_pkg::sat32(ang_ext);
            state_r     <= ST_CX;
            mul_start_r <= 1'b1;
          end
        end
        ST_CX: begin
          if (mul_done) begin
            px_r        <= mul_p[65:30];
            state_r     <= ST_CY;
            mul_start_r <= 1'b1;
          end
        end
        ST_CY: begin
          if (mul_done) begin
            py_r        <= mul_p[65:30];
            state_r     <= ST_PX;
            mul_start_r <= 1'b1;
          end
        end
        ST_PX: begin
          if (mul_done) begin
            neg_r       <= mul_p[DW-1];
            mag_r       <= mul_p[DW-1] ? -mul_p[DW-1:0] : mul_p[DW-1:0];
            state_r     <= ST_DX;
            div_start_r <= 1'b1;
          end
        end
        ST_DX: begin
          if (div_done) begin
            x_r         <= ddo_pkg::sat32(pos_sum_x);
            state_r     <= ST_PY;
            mul_start_r <= 1'b1;
          end
        end
        ST_PY: begin
          if (mul_done) begin
            neg_r       <= mul_p[DW-1];
            mag_r       <= mul_p[DW-1] ? -mul_p[DW-1:0] : mul_p[DW-1:0];
            state_r     <= ST_DY;
            div_start_r <= 1'b1;
          end
        end
        ST_DY: begin
          if (div_done) begin
            y_r         <= ddo_pkg::sat32(pos_sum_y);
            state_r     <= ST_H1;
            mul_start_r <= 1'b1;
          end
        end
        ST_H1: begin
          if (mul_done) begin
            hd_r        <= mul_p[AW-1:0];
            state_r     <= ST_H2;
            mul_start_r <= 1'b1;
          end
        end
        ST_H2: begin
          if (mul_done) begin
            // heading advances modulo a full turn
            yaw_r   <= yaw_r + mul_p[63:32];
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          // hold the pose until the output register is free
          if (!out_valid_r || out_chan.ready) begin
            out_valid_r <= 1'b1;
            o_x_r       <= x_r;
            o_y_r       <= y_r;
            o_yaw_r     <= yaw_r;
            o_lin_r     <= lin_r;
            o_ang_r     <= ang_r;
            o_stamp_r   <= stamp_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.pos_x        = o_x_r;
  assign out_chan.pos_y        = o_y_r;
  assign out_chan.heading      = o_yaw_r;
  assign out_chan.linear_speed = o_lin_r;
  assign out_chan.turn_rate    = o_ang_r;
  assign out_chan.out_stamp_us = o_stamp_r;

  // cos and sin must be settled before they feed the multiplier
  a_cordic_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (mul_start_r && (state_r == ST_CX || state_r == ST_CY)) |-> !cor_busy)
    else $error("cordic still busy at trig multiply");

  // never restart the shared multiplier mid-operation
  a_mul_free: assert property (@(posedge clk) disable iff (!rst_n)
    mul_start_r |-> !mul_busy)
    else $error("multiplier restarted while busy");

  // a request without speeds leaves the block idle
  a_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !in_chan.speeds_present) |=> (state_r == ST_IDLE))
    else $error("dropped request started work");

  // a pending pose is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_chan.ready) |=> (out_valid_r && $stable(o_stamp_r)))
    else $error("pending pose lost");
endmodule

@@ tb/sv/ddo_pose_checker.sv @@
`timescale 1ns / 100ps
// Pose checker: tracks the odometry state, predicts each pose and compares it.
module ddo_pose_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [ddo_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [23:0]                   cfg_wdata,
  ddo_in_if                             in_mon,
  ddo_out_if                            out_mon,
  output int                            fail_count,
  output int                            poses_pending
);
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] heading;
    logic signed [31:0] linear_speed;
    logic signed [31:0] turn_rate;
    logic [47:0]        stamp;
  } pose_t;

  localparam logic [31:0] ARC_STEP [32] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001,
    32'h00000000, 32'h00000000};

  logic [15:0]        radius;
  logic [23:0]        inv_sep;
  logic signed [31:0] cur_x, cur_y;
  logic [31:0]        cur_yaw;
  logic [47:0]        last_stamp;
  pose_t              pose_q[$];

  assign poses_pending = pose_q.size();

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Advance the pose by one sample and return the pose it yields.
  function automatic pose_t odometry_step(input logic signed [31:0] lsp,
                                          input logic signed [31:0] rsp,
                                          input logic [47:0] st);
    pose_t          p;
    longint         vl, vr, lin, ang, dt, cx, sy, dx, dy, mv;
    longint unsigned turn;
    logic [31:0]    z;
    vl  = longint'(lsp) * longint'({1'b0, radius});
    vr  = longint'(rsp) * longint'({1'b0, radius});
    lin = clamp32((vl + vr) >>> 17);
    ang = clamp32((((vl - vr) >>> 16) * longint'({1'b0, inv_sep})) >>> 16);
    dt  = longint'({16'd0, st}) - longint'({16'd0, last_stamp});
    if (dt <= 0 || dt > longint'(ddo_pkg::DT_LIMIT_US)) dt = ddo_pkg::DT_FALLBACK_US;
    last_stamp = st;
    // rotate the gain vector to the old heading; fold the left half-plane first
    cx = longint'(ddo_pkg::CORDIC_GAIN);
    sy = 0;
    z  = cur_yaw;
    if (z[31:30] == 2'd1 || z[31:30] == 2'd2) begin
      z  = z + 32'h80000000;
      cx = -cx;
    end
    for (int i = 0; i < ddo_pkg::CORDIC_STEPS_DEF; i++) begin
      dx = sy >>> i;
      dy = cx >>> i;
      if (!z[31]) begin
        cx = cx - dx; sy = sy + dy; z = z - ARC_STEP[i];
      end else begin
        cx = cx + dx; sy = sy - dy; z = z + ARC_STEP[i];
      end
    end
    mv    = (((lin * cx) >>> 30) * dt) / longint'(ddo_pkg::US_PER_S);
    cur_x = 32'(clamp32(longint'(cur_x) + mv));
    mv    = (((lin * sy) >>> 30) * dt) / longint'(ddo_pkg::US_PER_S);
    cur_y = 32'(clamp32(longint'(cur_y) + mv));
    turn    = longint'(ang * dt) * longint'(ddo_pkg::BAM_PER_RAD_US);
    cur_yaw = cur_yaw + turn[63:32];
    p.pos_x = cur_x;
    p.pos_y = cur_y;
    p.heading = cur_yaw;
    p.linear_speed = 32'(lin);
    p.turn_rate = 32'(ang);
    p.stamp = st;
    return p;
  endfunction

  always @(posedge clk) begin
    pose_t e;
    if (!rst_n) begin
      radius     <= 16'(ddo_pkg::RADIUS_RESET);
      inv_sep    <= 24'(ddo_pkg::SEP_RESET);
      cur_x      <= ddo_pkg::X_RESET;
      cur_y      <= '0;
      cur_yaw    <= '0;
      last_stamp <= '0;
      fail_count <= 0;
      pose_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == ddo_pkg::CFG_WHEEL_RADIUS) radius = cfg_wdata[15:0];
        else if (cfg_index == ddo_pkg::CFG_INV_SEP) inv_sep = cfg_wdata;
      end
      if (in_mon.valid && in_mon.ready && in_mon.speeds_present)
        pose_q.push_back(odometry_step(in_mon.left_speed, in_mon.right_speed,
                                       in_mon.stamp_us));
      if (out_mon.valid && out_mon.ready) begin
        if (pose_q.size() == 0) begin
          $error("pose with no request outstanding");
          fail_count++;
        end else begin
          e = pose_q.pop_front();
          if (out_mon.pos_x !== e.pos_x) begin
            $error("pos_x exp %0d got %0d", e.pos_x, out_mon.pos_x); fail_count++;
          end
          if (out_mon.pos_y !== e.pos_y) begin
            $error("pos_y exp %0d got %0d", e.pos_y, out_mon.pos_y); fail_count++;
          end
          if (out_mon.heading !== e.heading) begin
            $error("heading exp %0h got %0h", e.heading, out_mon.heading); fail_count++;
          end
          if (out_mon.linear_speed !== e.linear_speed) begin
            $error("linear_speed exp %0d got %0d", e.linear_speed, out_mon.linear_speed);
            fail_count++;
          end
          if (out_mon.turn_rate !== e.turn_rate) begin
            $error("turn_rate exp %0d got %0d", e.turn_rate, out_mon.turn_rate);
            fail_count++;
          end
          if (out_mon.out_stamp_us !== e.stamp) begin
            $error("out_stamp_us exp %0d got %0d", e.stamp, out_mon.out_stamp_us);
            fail_count++;
          end
        end
      end
    end
  end
endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps
// Top of the odometry testbench: stimulus, configuration phases and verdict.
module testbench;
  // indexes past the register map; writes there must be dropped
  localparam logic [ddo_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 2'd2;
  localparam logic [ddo_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 2'd3;
  localparam int SETTLE_CYCLES = 500;  // longer than the block spends on one request

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [ddo_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [23:0] cfg_wdata;
  int fail_count;
  int poses_pending;
  bit no_idle;
  logic [47:0] sent_stamp;

  ddo_in_if  in_chan ();
  ddo_out_if out_chan ();

  diff_drive_odometry dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_chan(in_chan), .out_chan(out_chan)
  );

  ddo_pose_checker chk (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_mon(in_chan), .out_mon(out_chan),
    .fail_count(fail_count), .poses_pending(poses_pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end

  // Mostly short gaps, now and then a long one; none while no_idle holds.
  function automatic int pick_gap();
    if (no_idle) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
    return $urandom_range(10, 80);
  endfunction

  // Stall the pose receiver at random.
  initial begin
    int stall;
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        stall--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall = pick_gap();
      end
    end
  end

  // Offer one wheel-speed request and hold it until taken.
  task automatic send_sample(input logic sp, input logic [31:0] lsp,
                             input logic [31:0] rsp, input logic [47:0] st);
    int gap;
    bit taken;
    gap = pick_gap();
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid          <= 1'b1;
    in_chan.speeds_present <= sp;
    in_chan.left_speed     <= lsp;
    in_chan.right_speed    <= rsp;
    in_chan.stamp_us       <= st;
    do begin
      @(negedge clk);
      taken = in_chan.ready;
      @(posedge clk);
    end while (!taken);
    if (sp) sent_stamp = st;
  endtask

  // Drop valid, drain all poses, then let any dropped request finish.
  task automatic drain();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (poses_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ddo_pkg::CFG_IDX_W-1:0] idx,
                           input logic [23:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Realistic samples in the main, odd ones and dropped ones now and then.
  task automatic random_samples(input int count);
    int kind;
    logic [31:0] lsp, rsp;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(0, 99);
      if (kind < 80) begin
        lsp = $signed($urandom_range(0, 40 * 65536)) - 20 * 65536;
        rsp = $signed($urandom_range(0, 40 * 65536)) - 20 * 65536;
        send_sample(1'b1, lsp, rsp, sent_stamp + $urandom_range(1, 30000));
      end else if (kind < 88) begin
        send_sample(1'b0, $urandom, $urandom, 48'({$urandom, $urandom}));
      end else if (kind < 95) begin
        send_sample(1'b1, $urandom, $urandom, sent_stamp + $urandom_range(0, 12000000));
      end else begin
        send_sample(1'b1, $urandom, $urandom, 48'({$urandom, $urandom}));
      end
    end
  endtask

  initial begin
    int waited;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_chan.valid = 1'b0;
    in_chan.speeds_present = 1'b0;
    in_chan.left_speed = '0;
    in_chan.right_speed = '0;
    in_chan.stamp_us = '0;
    no_idle = 1'b0;
    sent_stamp = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: speed extremes, stale, repeated and oversized time steps,
    // a dropped request, the stamp extremes, then headings in every quadrant.
    send_sample(1'b1, 32'h00010000, 32'h00010000, 48'd0);
    send_sample(1'b1, 32'h7FFFFFFF, 32'h7FFFFFFF, 48'd10000);
    send_sample(1'b1, 32'h80000000, 32'h80000000, 48'd20000);
    send_sample(1'b1, 32'h7FFFFFFF, 32'h80000000, 48'd30000);
    send_sample(1'b1, 32'h80000000, 32'h7FFFFFFF, 48'd40000);
    send_sample(1'b0, 32'hFFFFFFFF, 32'h00000000, 48'hFFFFFFFFFFFF);
    send_sample(1'b1, 32'h00010000, 32'hFFFF0000, 48'd35000);
    send_sample(1'b1, 32'h00010000, 32'hFFFF0000, 48'd35000);
    send_sample(1'b1, 32'h00020000, 32'h00000000, 48'd10035000);
    send_sample(1'b1, 32'h00020000, 32'h00000000, 48'd20035001);
    send_sample(1'b1, 32'h00000000, 32'h00000000, 48'hFFFFFFFFFFFF);
    send_sample(1'b1, 32'h00050000, 32'h00050000, 48'd5000);
    for (int q = 0; q < 8; q++)
      send_sample(1'b1, 32'h00400000, 32'hFFC00000, 48'd5000 + 48'(q + 1) * 48'd900000);
    for (int q = 0; q < 4; q++)
      send_sample(1'b1, 32'h00080000, 32'h00060000, sent_stamp + 48'd20000);
    drain();

    // Random phases, each under its own register setting.
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin
          write_reg(ddo_pkg::CFG_WHEEL_RADIUS, 24'd65535);
          write_reg(ddo_pkg::CFG_INV_SEP, 24'hFFFFFF);
        end
        1: begin
          write_reg(ddo_pkg::CFG_WHEEL_RADIUS, 24'd0);
          write_reg(ddo_pkg::CFG_INV_SEP, 24'd1);
        end
        2: begin
          write_reg(ddo_pkg::CFG_WHEEL_RADIUS, 24'hFFABCD);
          write_reg(ddo_pkg::CFG_INV_SEP, 24'd0);
        end
        3: begin
          write_reg(ddo_pkg::CFG_WHEEL_RADIUS, 24'd5000);
          write_reg(ddo_pkg::CFG_INV_SEP, 24'd200000);
          write_reg(CFG_IDX_SPARE_A, 24'h5A5A5A);
          write_reg(CFG_IDX_SPARE_B, 24'hA5A5A5);
        end
        default: begin
          write_reg(ddo_pkg::CFG_WHEEL_RADIUS, 24'($urandom));
          write_reg(ddo_pkg::CFG_INV_SEP, 24'($urandom));
        end
      endcase
      no_idle = (ph == 4);
      random_samples(105);
      drain();
    end

    waited = 0;
    while (poses_pending != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && poses_pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

@@ sim.f @@
hdl/ddo_pkg.sv
hdl/ddo_if.sv
hdl/ddo_sermul.sv
hdl/ddo_cdiv.sv
hdl/ddo_cordic.sv
hdl/diff_drive_odometry.sv
tb/sv/ddo_pose_checker.sv
tb/sv/testbench.sv
